// ----- design/text_terminal_ansi_color_engine_defines.svh -----
// Assertion macros shared by the terminal engine modules.
// Every macro expects clk_i and rst_ni to be visible at the place of use.
`ifndef TEXT_TERMINAL_ANSI_COLOR_ENGINE_DEFINES_SVH
`define TEXT_TERMINAL_ANSI_COLOR_ENGINE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define TTAC_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ttac assertion failed");

// Next-cycle implication, checked outside reset.
`define TTAC_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ttac assertion failed");

`endif

// ----- design/ttac_pkg.sv -----
// Package of the text terminal engine: codes, the queued command type and constants.
// Used by ttac_front, ttac_fifo, ttac_back and the top level.
package ttac_pkg;

  // Default screen size.
  localparam int RowsDef = 25;
  localparam int ColsDef = 80;

  // Cell address width, large enough for a screen of up to 64 x 128 cells.
  localparam int CellAw = 13;

  // Queue depth between front and back.
  localparam int FifoDepth = 4;

  // Configuration register indexes.
  localparam logic RegDefaultStyle  = 1'b0;
  localparam logic RegCursorVisible = 1'b1;

  // Reset values of configuration.
  localparam logic [7:0] DefaultStyleRst = 8'd15;

  // Byte codes.
  localparam logic [7:0] ChEsc   = 8'h1B;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChBrack = 8'h5B;
  localparam logic [7:0] ChM     = 8'h6D;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChSpace = 8'h20;

  // SGR numbers.
  localparam logic [7:0] SgrFgLo  = 8'd30;
  localparam logic [7:0] SgrFgHi  = 8'd37;
  localparam logic [7:0] SgrBgLo  = 8'd40;
  localparam logic [7:0] SgrBgHi  = 8'd47;
  localparam logic [7:0] SgrBfgLo = 8'd90;
  localparam logic [7:0] SgrBfgHi = 8'd97;
  localparam logic [7:0] SgrBfgOf = 8'd82;
  localparam logic [7:0] SgrBbgLo = 8'd100;
  localparam logic [7:0] SgrBbgHi = 8'd107;
  localparam logic [7:0] SgrBbgOf = 8'd92;

  typedef enum logic [2:0] {
    FN_PUT    = 3'd0,
    FN_READ   = 3'd1,
    FN_CURSOR = 3'd2,
    FN_STYLE  = 3'd3,
    FN_CLEAR  = 3'd4,
    FN_SCROLL = 3'd5
  } func_e;

  typedef enum logic [1:0] {
    PH_TEXT  = 2'd0,
    PH_ESC   = 2'd1,
    PH_DIGIT = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_READ  = 2'd2
  } cmd_kind_e;

  typedef enum logic {
    BE_RUN  = 1'b0,
    BE_FILL = 1'b1
  } back_state_e;

  // One queued command with the status the result reports.
  typedef struct packed {
    cmd_kind_e          kind;
    logic               fill;
    logic               swap;
    logic [CellAw-1:0]  base;
    logic [6:0]         col;
    logic [7:0]         ch;
    logic [7:0]         st;
    logic [4:0]         cur_row;
    logic [6:0]         cur_col;
    logic [7:0]         style;
  } cmd_t;

endpackage

// ----- design/ttac_front.sv -----
// Front end of the terminal engine: parser, cursor, style, scroll and row flags.
// Depends on ttac_pkg; emits one ttac_pkg::cmd_t per accepted item.
module ttac_front #(
  parameter int Rows = ttac_pkg::RowsDef,
  parameter int Cols = ttac_pkg::ColsDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [2:0]       func_i,
  input  logic [7:0]       data_byte_i,
  input  logic [4:0]       row_sel_i,
  input  logic [6:0]       col_sel_i,
  input  logic [7:0]       style_in_i,
  input  logic [7:0]       default_style_i,
  input  logic             cursor_visible_i,
  output ttac_pkg::cmd_t   cmd_o
);

  localparam int Rw = $clog2(Rows);
  localparam int Cw = $clog2(Cols);

  logic [Rw-1:0]    row_q, row_d;
  logic [Cw-1:0]    col_q, col_d;
  logic [Rw-1:0]    top_q, top_d;
  logic [7:0]       style_q, style_d;
  ttac_pkg::phase_e phase_q, phase_d;
  logic [7:0]       total_q, total_d;
  logic [Rows-1:0]  blank_q, blank_d;

  // Physical row of a logical row.
  function automatic logic [Rw-1:0] phys(input logic [Rw-1:0] top, input logic [Rw-1:0] r);
    logic [Rw:0] s;
    s = {1'b0, top} + {1'b0, r};
    if (s >= (Rw+1)'(Rows)) s = s - (Rw+1)'(Rows);
    return s[Rw-1:0];
  endfunction

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q   <= '0;
      col_q   <= '0;
      top_q   <= '0;
      style_q <= ttac_pkg::DefaultStyleRst;
      phase_q <= ttac_pkg::PH_TEXT;
      total_q <= '0;
      blank_q <= '1;
    end else if (accept_i) begin
      row_q   <= row_d;
      col_q   <= col_d;
      top_q   <= top_d;
      style_q <= style_d;
      phase_q <= phase_d;
      total_q <= total_d;
      blank_q <= blank_d;
    end
  end

  // Operation decode and state update for the item at the input.
  always_comb begin
    logic [Rw-1:0] rs;
    logic [Cw-1:0] cs;
    logic [Rw-1:0] pr;
    logic [Cw:0]   ncol;
    logic          plain;
    logic          nl;
    logic [7:0]    b;
    logic [7:0]    n;
    row_d   = row_q;
    col_d   = col_q;
    top_d   = top_q;
    style_d = style_q;
    phase_d = phase_q;
    total_d = total_q;
    blank_d = blank_q;
    plain   = 1'b0;
    nl      = 1'b0;
    b       = data_byte_i;
    n       = total_q;
    ncol    = '0;
    cmd_o   = '0;
    cmd_o.kind = ttac_pkg::CMD_NONE;
    rs = (row_sel_i > (Rows - 1)) ? Rw'(Rows - 1) : Rw'(row_sel_i);
    cs = (col_sel_i > (Cols - 1)) ? Cw'(Cols - 1) : Cw'(col_sel_i);
    pr = phys(top_q, row_q);

    case (func_i)
      ttac_pkg::FN_PUT: begin
        // Escape parser.
        case (phase_q)
          ttac_pkg::PH_ESC: begin
            if (b == ttac_pkg::ChBrack) begin
              phase_d = ttac_pkg::PH_DIGIT;
              total_d = '0;
            end else begin
              phase_d = ttac_pkg::PH_TEXT;
              plain   = 1'b1;
            end
          end
          ttac_pkg::PH_DIGIT: begin
            if (b inside {[ttac_pkg::ChZero:ttac_pkg::ChNine]}) begin
              total_d = 8'(total_q * 8'd10 + {4'd0, b[3:0]});
            end else begin
              phase_d = ttac_pkg::PH_TEXT;
              if (b == ttac_pkg::ChM) begin
                if (n == 8'd0) begin
                  style_d = default_style_i;
                end else if (n inside {[ttac_pkg::SgrFgLo:ttac_pkg::SgrFgHi]}) begin
                  style_d = {style_q[7:4], 4'(n - ttac_pkg::SgrFgLo)};
                end else if (n inside {[ttac_pkg::SgrBgLo:ttac_pkg::SgrBgHi]}) begin
                  style_d = {4'(n - ttac_pkg::SgrBgLo), style_q[3:0]};
                end else if (n inside {[ttac_pkg::SgrBfgLo:ttac_pkg::SgrBfgHi]}) begin
                  style_d = {style_q[7:4], 4'(n - ttac_pkg::SgrBfgOf)};
                end else if (n inside {[ttac_pkg::SgrBbgLo:ttac_pkg::SgrBbgHi]}) begin
                  style_d = {4'(n - ttac_pkg::SgrBbgOf), style_q[3:0]};
                end
              end else begin
                plain = 1'b1;
              end
            end
          end
          default: begin
            phase_d = ttac_pkg::PH_TEXT;
            plain   = 1'b1;
          end
        endcase

        // Ordinary byte handling.
        if (plain) begin
          if (b == ttac_pkg::ChEsc) begin
            phase_d = ttac_pkg::PH_ESC;
          end else if (b == ttac_pkg::ChLf) begin
            nl = 1'b1;
          end else if (b == ttac_pkg::ChCr) begin
            col_d = '0;
          end else begin
            cmd_o.kind = ttac_pkg::CMD_WRITE;
            cmd_o.fill = blank_q[pr];
            cmd_o.base = ttac_pkg::CellAw'(ttac_pkg::CellAw'(pr) * ttac_pkg::CellAw'(Cols));
            cmd_o.col  = 7'(col_q);
            cmd_o.ch   = b;
            cmd_o.st   = style_q;
            blank_d[pr] = 1'b0;
            ncol = {1'b0, col_q} + (Cw+1)'(1);
            if (ncol >= (Cw+1)'(Cols)) nl = 1'b1;
            else col_d = ncol[Cw-1:0];
          end
        end

        // Line feed, with scroll at the bottom.
        if (nl) begin
          col_d = '0;
          if (row_q >= Rw'(Rows - 1)) begin
            blank_d[top_q] = 1'b1;
            top_d = phys(top_q, Rw'(1));
          end else begin
            row_d = row_q + Rw'(1);
          end
        end
      end
      ttac_pkg::FN_READ: begin
        pr = phys(top_q, rs);
        cmd_o.swap = cursor_visible_i && (rs == row_q) && (cs == col_q);
        cmd_o.base = ttac_pkg::CellAw'(ttac_pkg::CellAw'(pr) * ttac_pkg::CellAw'(Cols));
        cmd_o.col  = 7'(cs);
        if (blank_q[pr]) begin
          cmd_o.ch = ttac_pkg::ChSpace;
          cmd_o.st = default_style_i;
        end else begin
          cmd_o.kind = ttac_pkg::CMD_READ;
        end
      end
      ttac_pkg::FN_CURSOR: begin
        row_d = rs;
        col_d = cs;
      end
      ttac_pkg::FN_STYLE: begin
        style_d = style_in_i;
      end
      ttac_pkg::FN_CLEAR: begin
        blank_d = '1;
      end
      ttac_pkg::FN_SCROLL: begin
        blank_d[top_q] = 1'b1;
        top_d = phys(top_q, Rw'(1));
      end
      default: begin
      end
    endcase

    cmd_o.cur_row = 5'(row_d);
    cmd_o.cur_col = 7'(col_d);
    cmd_o.style   = style_d;
  end

endmodule

// ----- design/ttac_fifo.sv -----
// Short command queue between the front and back of the terminal engine.
// Depends on ttac_pkg for the command type and depth.
`include "text_terminal_ansi_color_engine_defines.svh"
module ttac_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  ttac_pkg::cmd_t data_i,
  input  logic           pop_i,
  output ttac_pkg::cmd_t head_o,
  output logic           empty_o,
  output logic           full_o
);

  localparam int Aw = $clog2(ttac_pkg::FifoDepth);

  ttac_pkg::cmd_t mem_q [ttac_pkg::FifoDepth];
  logic [Aw-1:0]  wr_q, rd_q;
  logic [Aw:0]    cnt_q, cnt_d;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == (Aw+1)'(ttac_pkg::FifoDepth));
  assign head_o  = mem_q[rd_q];

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

  // Pointers and fill count.
  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) cnt_d = cnt_q + (Aw+1)'(1);
    else if (!push_i && pop_i) cnt_d = cnt_q - (Aw+1)'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + Aw'(1);
      if (pop_i) rd_q <= rd_q + Aw'(1);
      cnt_q <= cnt_d;
    end
  end

  // The count tracks the pointer distance and never exceeds the depth.
  `TTAC_ASSERT_IMP(a_cnt_range, 1'b1, cnt_q <= (Aw+1)'(ttac_pkg::FifoDepth))
  `TTAC_ASSERT_IMP(a_no_pop_empty, empty_o, !pop_i)
  `TTAC_ASSERT_IMP(a_no_push_full, full_o, !push_i)

endmodule

// ----- design/ttac_back.sv -----
// Back end of the terminal engine: cell memory, row fill sweep and result register.
// Depends on ttac_pkg; takes commands from ttac_fifo.
`include "text_terminal_ansi_color_engine_defines.svh"
module ttac_back #(
  parameter int Rows = ttac_pkg::RowsDef,
  parameter int Cols = ttac_pkg::ColsDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  ttac_pkg::cmd_t head_i,
  input  logic           empty_i,
  output logic           pop_o,
  input  logic [7:0]     default_style_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic [7:0]     cell_char_o,
  output logic [7:0]     cell_style_o,
  output logic [4:0]     cursor_row_out_o,
  output logic [6:0]     cursor_col_out_o,
  output logic [7:0]     style_out_o
);

  localparam int Cells = Rows * Cols;
  localparam int Aw    = $clog2(Cells);
  localparam int Cw    = $clog2(Cols);

  logic [15:0]             mem [Cells];
  logic [15:0]             rdata_q;
  ttac_pkg::cmd_t          s1_q;
  logic                    s1_valid_q;
  ttac_pkg::back_state_e   state_q, state_d;
  logic [Cw-1:0]           fcol_q, fcol_d;
  logic                    fdone_q, fdone_d;
  logic                    adv;
  logic                    we, re;
  logic [Aw-1:0]           waddr, raddr;
  logic [15:0]             wdata;
  logic [7:0]              st_raw;

  assign adv = !s1_valid_q || !out_stall_i;

  // Sweep control and command issue.
  always_comb begin
    state_d = state_q;
    fcol_d  = fcol_q;
    fdone_d = fdone_q;
    pop_o   = 1'b0;
    we      = 1'b0;
    re      = 1'b0;
    waddr   = Aw'(head_i.base + ttac_pkg::CellAw'(head_i.col));
    raddr   = waddr;
    wdata   = {head_i.st, head_i.ch};
    case (state_q)
      ttac_pkg::BE_FILL: begin
        we    = 1'b1;
        waddr = Aw'(head_i.base + ttac_pkg::CellAw'(fcol_q));
        wdata = {default_style_i, ttac_pkg::ChSpace};
        fcol_d = fcol_q + Cw'(1);
        if (fcol_q == Cw'(Cols - 1)) begin
          state_d = ttac_pkg::BE_RUN;
          fdone_d = 1'b1;
        end
      end
      default: begin
        if (!empty_i) begin
          if (head_i.kind == ttac_pkg::CMD_WRITE && head_i.fill && !fdone_q) begin
            state_d = ttac_pkg::BE_FILL;
            fcol_d  = '0;
          end else if (adv) begin
            pop_o   = 1'b1;
            fdone_d = 1'b0;
            we = (head_i.kind == ttac_pkg::CMD_WRITE);
            re = (head_i.kind == ttac_pkg::CMD_READ);
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ttac_pkg::BE_RUN;
      fcol_q     <= '0;
      fdone_q    <= 1'b0;
      s1_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      fcol_q  <= fcol_d;
      fdone_q <= fdone_d;
      if (adv) s1_valid_q <= pop_o;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (pop_o) s1_q <= head_i;
  end

  // Cell memory.
  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk_i) begin
    if (re) rdata_q <= mem[raddr];
  end

  // Result fields.
  always_comb begin
    cell_char_o = s1_q.ch;
    st_raw      = s1_q.st;
    if (s1_q.kind == ttac_pkg::CMD_READ) begin
      cell_char_o = rdata_q[7:0];
      st_raw      = rdata_q[15:8];
    end else if (s1_q.kind == ttac_pkg::CMD_WRITE) begin
      cell_char_o = '0;
      st_raw      = '0;
    end
    cell_style_o = s1_q.swap ? {st_raw[3:0], st_raw[7:4]} : st_raw;
  end

  assign out_valid_o      = s1_valid_q;
  assign cursor_row_out_o = s1_q.cur_row;
  assign cursor_col_out_o = s1_q.cur_col;
  assign style_out_o      = s1_q.style;

  // The sweep only runs for a fill command at the queue head, and nothing issues meanwhile.
  `TTAC_ASSERT_IMP(a_fill_has_head, state_q == ttac_pkg::BE_FILL, !empty_i && head_i.fill)
  `TTAC_ASSERT_IMP(a_no_pop_in_fill, state_q == ttac_pkg::BE_FILL, !pop_o)
  `TTAC_ASSERT_NXT(a_held_when_stalled, out_valid_o && out_stall_i, out_valid_o)

endmodule

// ----- design/text_terminal_ansi_color_engine.sv -----
// Order: an accepted item enters the queue, and the back end pops it from the queue head and
// registers its result; a write into a blank row first starts a blank sweep through that
// row and is popped only when the sweep through every cell of the row is done.
// Throughput: one item per cycle while the output is not stalled; a row sweep holds the
// queue, and the input stalls once the queue is full.
// Reset: asynchronous, active low; clears cursor, parser, scroll offset, queue and
// marks all rows blank. Cell memory is not cleared; blank rows read as spaces.
module text_terminal_ansi_color_engine #(
  parameter int Rows = ttac_pkg::RowsDef,
  parameter int Cols = ttac_pkg::ColsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  func_i,
  input  logic [7:0]  data_byte_i,
  input  logic [4:0]  row_sel_i,
  input  logic [6:0]  col_sel_i,
  input  logic [7:0]  style_in_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  cell_char_o,
  output logic [7:0]  cell_style_o,
  output logic [4:0]  cursor_row_out_o,
  output logic [6:0]  cursor_col_out_o,
  output logic [7:0]  style_out_o
);

  logic [7:0]     default_style_q;
  logic           cursor_visible_q;
  logic           accept, full, empty, pop;
  ttac_pkg::cmd_t cmd, head;

  // Configuration registers.
  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      default_style_q  <= ttac_pkg::DefaultStyleRst;
      cursor_visible_q <= 1'b1;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == ttac_pkg::RegDefaultStyle) default_style_q <= pwdata[7:0];
      else cursor_visible_q <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == ttac_pkg::RegDefaultStyle) prdata[7:0] = default_style_q;
    else prdata[0] = cursor_visible_q;
  end

  // Input handshake.
  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  ttac_front #(.Rows(Rows), .Cols(Cols)) u_front (
    .clk_i,
    .rst_ni,
    .accept_i         (accept),
    .func_i,
    .data_byte_i,
    .row_sel_i,
    .col_sel_i,
    .style_in_i,
    .default_style_i  (default_style_q),
    .cursor_visible_i (cursor_visible_q),
    .cmd_o            (cmd)
  );

  ttac_fifo u_fifo (
    .clk_i,
    .rst_ni,
    .push_i  (accept),
    .data_i  (cmd),
    .pop_i   (pop),
    .head_o  (head),
    .empty_o (empty),
    .full_o  (full)
  );

  ttac_back #(.Rows(Rows), .Cols(Cols)) u_back (
    .clk_i,
    .rst_ni,
    .head_i          (head),
    .empty_i         (empty),
    .pop_o           (pop),
    .default_style_i (default_style_q),
    .out_valid_o,
    .out_stall_i,
    .cell_char_o,
    .cell_style_o,
    .cursor_row_out_o,
    .cursor_col_out_o,
    .style_out_o
  );

endmodule
